[design/sis_pkg.sv]
// ----------------------------------------------------------------------------
// sis_pkg
// Shared codes and types for the sparse integer set: opcodes, field widths
// and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package sis_pkg;

	localparam int OpW  = 3;	// opcode width
	localparam int ValW = 8;	// value, position, element and stored entry width
	localparam int CntW = 9;	// member count width

	localparam logic [OpW-1:0] OP_TEST  = 3'd0;
	localparam logic [OpW-1:0] OP_ADD   = 3'd1;
	localparam logic [OpW-1:0] OP_ERASE = 3'd2;
	localparam logic [OpW-1:0] OP_CLEAR = 3'd3;
	localparam logic [OpW-1:0] OP_POP   = 3'd4;
	localparam logic [OpW-1:0] OP_READ  = 3'd5;

	// controller -> datapath
	typedef struct packed {
		logic load;	// latch item, launch memory reads
		logic commit;	// apply writes, load result register
	} sis_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic out_busy;	// result register full and stalled
	} sis_stat_t;

endpackage

`default_nettype wire

[design/sis_ram.sv]
// ----------------------------------------------------------------------------
// sis_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sis_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

[design/sis_ctrl.sv]
// ----------------------------------------------------------------------------
// sis_ctrl
// Two-state controller: take an item, then commit it once the result
// register can accept.
// ----------------------------------------------------------------------------
`default_nettype none

module sis_ctrl import sis_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_stall,
	input  wire sis_stat_t stat,
	output sis_cmd_t       cmd
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d    = state_q;
		cmd.load   = 1'b0;
		cmd.commit = 1'b0;
		in_stall   = 1'b1;
		case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				if (!stat.out_busy) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

[design/sis_dpath.sv]
// ----------------------------------------------------------------------------
// sis_dpath
// Set storage and operation logic: dense and slot RAMs, member bit vector,
// member count and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module sis_dpath import sis_pkg::*; #(
	parameter int UNIVERSE = 256
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire sis_cmd_t        cmd,
	output sis_stat_t            stat,
	input  wire logic [OpW-1:0]  opcode,
	input  wire logic [ValW-1:0] value,
	input  wire logic [ValW-1:0] position,
	output logic                 out_valid,
	input  wire logic            out_stall,
	output logic                 flag,
	output logic      [ValW-1:0] element,
	output logic      [CntW-1:0] count,
	output logic                 error
);

	// values are 8 bits wide, so storage never needs more than 256 entries
	localparam int Depth = (UNIVERSE < (1 << ValW)) ? UNIVERSE : (1 << ValW);
	localparam int AW    = $clog2(Depth);

	logic [OpW-1:0]  op_q;
	logic [ValW-1:0] value_q;
	logic [ValW-1:0] pos_q;
	logic [CntW-1:0] count_q;
	logic [Depth-1:0] bits_q;
	logic            out_valid_q;

	logic [CntW-1:0] count_m1;
	logic [ValW-1:0] dense_rd, slot_rd;

	logic            d_we, s_we;
	logic [AW-1:0]   d_waddr, s_waddr;
	logic [ValW-1:0] d_wdata, s_wdata;

	logic            n_flag, n_err;
	logic [ValW-1:0] n_elem;
	logic [CntW-1:0] n_count;
	logic            bit_set, bit_clr, clr_all;
	logic [AW-1:0]   bit_idx;

	logic            in_range, is_mem;
	logic [AW-1:0]   vidx, lidx;

	assign count_m1 = count_q - CntW'(1);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= opcode;
			value_q <= value;
			pos_q   <= position;
		end
	end

	sis_ram #(.WIDTH(ValW), .DEPTH(Depth)) u_dense (
		.clk   (clk),
		.we    (d_we & cmd.commit),
		.waddr (d_waddr),
		.wdata (d_wdata),
		.re    (cmd.load),
		.raddr ((opcode == OP_READ) ? position[AW-1:0] : count_m1[AW-1:0]),
		.rdata (dense_rd)
	);

	sis_ram #(.WIDTH(ValW), .DEPTH(Depth)) u_slot (
		.clk   (clk),
		.we    (s_we & cmd.commit),
		.waddr (s_waddr),
		.wdata (s_wdata),
		.re    (cmd.load),
		.raddr (value[AW-1:0]),
		.rdata (slot_rd)
	);

	assign in_range = 32'(value_q) < UNIVERSE;
	assign vidx     = value_q[AW-1:0];
	assign lidx     = dense_rd[AW-1:0];
	assign is_mem   = in_range && bits_q[vidx];

	always_comb begin
		n_flag  = 1'b0;
		n_elem  = '0;
		n_err   = 1'b0;
		n_count = count_q;
		d_we    = 1'b0;
		d_waddr = count_q[AW-1:0];
		d_wdata = value_q;
		s_we    = 1'b0;
		s_waddr = vidx;
		s_wdata = count_q[ValW-1:0];
		bit_set = 1'b0;
		bit_clr = 1'b0;
		bit_idx = vidx;
		clr_all = 1'b0;
		case (op_q)
			OP_TEST: begin
				n_flag = is_mem;
			end
			OP_ADD: begin
				if (in_range && !bits_q[vidx]) begin
					d_we    = 1'b1;
					s_we    = 1'b1;
					bit_set = 1'b1;
					n_count = count_q + CntW'(1);
					n_flag  = 1'b1;
				end
			end
			OP_ERASE: begin
				// last member moves into the freed slot
				if (is_mem) begin
					d_we    = 1'b1;
					d_waddr = slot_rd[AW-1:0];
					d_wdata = dense_rd;
					s_we    = 1'b1;
					s_waddr = lidx;
					s_wdata = slot_rd;
					bit_clr = 1'b1;
					n_count = count_m1;
					n_flag  = 1'b1;
				end
			end
			OP_CLEAR: begin
				clr_all = 1'b1;
				n_count = '0;
			end
			OP_POP: begin
				if (count_q == '0) begin
					n_err = 1'b1;
				end else begin
					bit_clr = 1'b1;
					bit_idx = lidx;
					n_count = count_m1;
					n_elem  = dense_rd;
					n_flag  = 1'b1;
				end
			end
			OP_READ: begin
				if ({1'b0, pos_q} < count_q) begin
					n_elem = dense_rd;
					n_flag = 1'b1;
				end else begin
					n_err = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				count_q     <= n_count;
				out_valid_q <= 1'b1;
				if (clr_all) begin
					bits_q <= '0;
				end else if (bit_set) begin
					bits_q[bit_idx] <= 1'b1;
				end else if (bit_clr) begin
					bits_q[bit_idx] <= 1'b0;
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			flag    <= n_flag;
			element <= n_elem;
			count   <= n_count;
			error   <= n_err;
		end
	end

	assign out_valid     = out_valid_q;
	assign stat.out_busy = out_valid_q && out_stall;

endmodule

`default_nettype wire

[design/sparse_integer_set_core.sv]
// Result valid rises at the commit edge, which comes in exec after the accepting
// edge once the result register can accept. No new item is taken until the last
// commits; the registered read of the dense and slot RAMs must return first.
// A waiting result does not block the next accept; commit waits on it.
// Reset (arst_n low, asynchronous): count zero, all member bits clear,
// result register empty. RAM contents are not cleared and need no sweep.
// ----------------------------------------------------------------------------
// sparse_integer_set_core
// Sparse integer set over 0..UNIVERSE-1: test, add, erase, clear, pop of
// the last member and read by dense position, one result per item.
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_integer_set_core import sis_pkg::*; #(
	parameter int UNIVERSE = 256	// values at or above this are never members
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	// item channel
	input  wire logic            in_valid,
	output logic                 in_stall,
	input  wire logic [OpW-1:0]  opcode,
	input  wire logic [ValW-1:0] value,
	input  wire logic [ValW-1:0] position,
	// result channel
	output logic                 out_valid,
	input  wire logic            out_stall,
	output logic                 flag,
	output logic      [ValW-1:0] element,
	output logic      [CntW-1:0] count,
	output logic                 error
);

	sis_cmd_t  cmd;
	sis_stat_t stat;

	// Controller: idle -> exec. In idle an item is taken and the RAM reads
	// are launched; in exec the read data is in hand and the item commits
	// as soon as the result register is free or being drained.
	sis_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Datapath: dense array (members in insertion order), slot array
	// (value -> dense slot), member bit vector in flops so clear drops every
	// member bit at once, member count and the result register. Erase reads the slot of
	// the value and the last member in parallel, then writes both RAMs.
	sis_dpath #(.UNIVERSE(UNIVERSE)) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.opcode    (opcode),
		.value     (value),
		.position  (position),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.flag      (flag),
		.element   (element),
		.count     (count),
		.error     (error)
	);

endmodule

`default_nettype wire

[verif/sis_set_checker.sv]
// ----------------------------------------------------------------------------
// sis_set_checker
// Watches both channels of the sparse integer set and keeps its own copy of
// the set. Each accepted item is applied to that copy, and the reply it
// predicts is queued. Each accepted result is checked field by field against
// the oldest queued reply.
// ----------------------------------------------------------------------------
`default_nettype none

module sis_set_checker import sis_pkg::*; #(
	parameter int UNIVERSE = 256
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	input  wire logic            in_stall,
	input  wire logic [OpW-1:0]  opcode,
	input  wire logic [ValW-1:0] value,
	input  wire logic [ValW-1:0] position,
	input  wire logic            out_valid,
	input  wire logic            out_stall,
	input  wire logic            flag,
	input  wire logic [ValW-1:0] element,
	input  wire logic [CntW-1:0] count,
	input  wire logic            error,
	output int                   failures,
	output int                   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic            flag;
		logic [ValW-1:0] element;
		logic [CntW-1:0] count;
		logic            error;
	} set_reply_t;

	// shadow copy of the set
	logic [ValW-1:0]     dense_slots [UNIVERSE];
	logic [ValW-1:0]     slot_of [UNIVERSE];
	logic [UNIVERSE-1:0] member_mask;
	logic [CntW-1:0]     members;

	set_reply_t replies_due [$];

	initial begin
		failures = 0;
		pending  = 0;
		for (int i = 0; i < UNIVERSE; i++) begin
			dense_slots[i] = '0;
			slot_of[i]     = '0;
		end
	end

	task automatic note_mismatch(input string msg);
		$display("%0t ns sis_set_checker: %s", $time, msg);
		failures++;
	endtask

	// last member fills the freed slot
	function automatic void drop_member(input logic [ValW-1:0] v);
		logic [ValW-1:0] hole;
		logic [ValW-1:0] tail;
		hole = slot_of[v];
		tail = dense_slots[members - 1'b1];
		dense_slots[hole] = tail;
		slot_of[tail]     = hole;
		member_mask[v]    = 1'b0;
		members           = members - 1'b1;
	endfunction

	function automatic set_reply_t apply_set_op(input logic [OpW-1:0] op,
			input logic [ValW-1:0] v, input logic [ValW-1:0] pos);
		set_reply_t      r;
		logic            in_universe;
		logic [ValW-1:0] tail;
		r = '0;
		in_universe = (int'(v) < UNIVERSE);
		case (op)
			OP_TEST: begin
				r.flag = in_universe && member_mask[v];
			end
			OP_ADD: begin
				if (in_universe && !member_mask[v] && members < UNIVERSE) begin
					dense_slots[members[ValW-1:0]] = v;
					slot_of[v]     = members[ValW-1:0];
					member_mask[v] = 1'b1;
					members        = members + 1'b1;
					r.flag         = 1'b1;
				end
			end
			OP_ERASE: begin
				if (in_universe && member_mask[v] && members != 0) begin
					drop_member(v);
					r.flag = 1'b1;
				end
			end
			OP_CLEAR: begin
				member_mask = '0;
				members     = '0;
			end
			OP_POP: begin
				if (members == 0) begin
					r.error = 1'b1;
				end else begin
					tail = dense_slots[members - 1'b1];
					if (member_mask[tail])
						drop_member(tail);
					else
						members = members - 1'b1;
					r.element = tail;
					r.flag    = 1'b1;
				end
			end
			OP_READ: begin
				if (pos < members) begin
					r.element = dense_slots[pos];
					r.flag    = 1'b1;
				end else begin
					r.error = 1'b1;
				end
			end
			default: ;
		endcase
		r.count = members;
		return r;
	endfunction

	always @(posedge clk) begin
		set_reply_t got;
		set_reply_t want;
		if (!arst_n) begin
			member_mask = '0;
			members     = '0;
			replies_due.delete();
		end else begin
			// a result never belongs to an item taken at the same edge
			if (out_valid && !out_stall) begin
				got = '{flag, element, count, error};
				if (replies_due.size() == 0) begin
					note_mismatch($sformatf("result with no item outstanding: %p", got));
				end else begin
					want = replies_due.pop_front();
					if (got.flag !== want.flag)
						note_mismatch($sformatf("flag %0b, expected %0b",
							got.flag, want.flag));
					if (got.element !== want.element)
						note_mismatch($sformatf("element %0d, expected %0d",
							got.element, want.element));
					if (got.count !== want.count)
						note_mismatch($sformatf("count %0d, expected %0d",
							got.count, want.count));
					if (got.error !== want.error)
						note_mismatch($sformatf("error %0b, expected %0b",
							got.error, want.error));
				end
			end
			if (in_valid && !in_stall)
				replies_due.push_back(apply_set_op(opcode, value, position));
		end
		pending = replies_due.size();
	end

endmodule

`default_nettype wire

[verif/tb_sparse_integer_set_core.sv]
// ----------------------------------------------------------------------------
// tb_sparse_integer_set_core
// Drives items into the sparse integer set core with random gaps and random
// result back-pressure. A directed run hits the corner cases first: empty
// set, duplicate add, erase with a move, pop, reads in and out of range,
// spare opcodes and clear. Random traffic over a small value pool follows,
// then a full fill of the universe. sis_set_checker does all the checking.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_sparse_integer_set_core;
	import sis_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int UNIVERSE = 256;
	localparam int HANG_LIMIT = 2000;	// cycles with no handshake on either side

	// codes the block must treat as no-ops
	localparam logic [OpW-1:0] OP_SPARE_LO = 3'd6;
	localparam logic [OpW-1:0] OP_SPARE_HI = 3'd7;

	typedef enum {TRAFFIC_QUIET, TRAFFIC_NORMAL, TRAFFIC_HEAVY} traffic_t;

	logic            clk = 1'b0;
	logic            arst_n;
	logic            in_valid;
	logic            in_stall;
	logic [OpW-1:0]  opcode;
	logic [ValW-1:0] value;
	logic [ValW-1:0] position;
	logic            out_valid;
	logic            out_stall = 1'b0;
	logic            flag;
	logic [ValW-1:0] element;
	logic [CntW-1:0] count;
	logic            error;

	int       failures;
	int       pending;
	int       idle_cycles = 0;
	int       stall_left  = 0;
	traffic_t traffic = TRAFFIC_NORMAL;

	always #2 clk = ~clk;

	sparse_integer_set_core #(.UNIVERSE(UNIVERSE)) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.opcode   (opcode),
		.value    (value),
		.position (position),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.flag     (flag),
		.element  (element),
		.count    (count),
		.error    (error)
	);

	sis_set_checker #(.UNIVERSE(UNIVERSE)) checker_i (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.opcode   (opcode),
		.value    (value),
		.position (position),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.flag     (flag),
		.element  (element),
		.count    (count),
		.error    (error),
		.failures (failures),
		.pending  (pending)
	);

	// Result back-pressure. Stall bursts are mostly short, and now and then long
	// enough to fill the core. Quiet mode gives stretches with no stall at all;
	// heavy mode stalls far more often.
	always @(negedge clk) begin
		int roll;
		int stall_odds;
		roll = $urandom_range(0, 99);
		stall_odds = (traffic == TRAFFIC_HEAVY) ? 60 : 25;
		if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (traffic == TRAFFIC_QUIET || roll >= stall_odds) begin
			out_stall <= 1'b0;
		end else begin
			// burst length counts this cycle
			if ($urandom_range(0, 99) < 90)
				stall_left = $urandom_range(0, 2);
			else
				stall_left = $urandom_range(9, 39);
			out_stall <= 1'b1;
		end
	end

	// Hang detection: any accept on either side restarts the count.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= HANG_LIMIT) begin
			$display("tb_sparse_integer_set_core: FAIL");
			$finish;
		end
	end

	// Sender gap before an item: mostly none or short, a few long ones.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (traffic == TRAFFIC_QUIET || roll < 55)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 8);
		return $urandom_range(15, 40);
	endfunction

	// Entered and left at a falling edge. Valid drops only across a gap, so
	// back-to-back items keep it high without a second assignment.
	task automatic issue_op(input logic [OpW-1:0] op, input logic [ValW-1:0] v,
			input logic [ValW-1:0] pos);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		opcode   <= op;
		value    <= v;
		position <= pos;
		do
			@(posedge clk);
		while (!(in_valid && !in_stall));
		@(negedge clk);
	endtask

	// Random item over a small value pool so that tests, erases and reads
	// mostly land on real members; the full byte range shows up too.
	task automatic issue_random_op();
		int              roll;
		logic [OpW-1:0]  op;
		logic [ValW-1:0] v;
		logic [ValW-1:0] pos;
		roll = $urandom_range(0, 99);
		if (roll < 18)      op = OP_TEST;
		else if (roll < 48) op = OP_ADD;
		else if (roll < 66) op = OP_ERASE;
		else if (roll < 75) op = OP_POP;
		else if (roll < 91) op = OP_READ;
		else if (roll < 93) op = OP_CLEAR;
		else if (roll < 96) op = OP_SPARE_LO;
		else                op = OP_SPARE_HI;
		v   = ($urandom_range(0, 3) != 0) ? ValW'($urandom_range(0, 31))
			: ValW'($urandom_range(0, 255));
		pos = ($urandom_range(0, 4) != 0) ? ValW'($urandom_range(0, 24))
			: ValW'($urandom_range(0, 255));
		issue_op(op, v, pos);
	endtask

	initial begin
		logic [ValW-1:0] fill_order [UNIVERSE];
		logic [ValW-1:0] swap;
		int              pick;

		arst_n    = 1'b0;
		in_valid  = 1'b0;
		opcode    = OP_TEST;
		value     = '0;
		position  = '0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// directed corners
		issue_op(OP_TEST,  8'd5,   8'd0);	// empty set
		issue_op(OP_POP,   8'd0,   8'd0);	// pop on empty -> error
		issue_op(OP_READ,  8'd0,   8'd0);	// read on empty -> error
		issue_op(OP_ERASE, 8'd5,   8'd0);	// erase non-member
		issue_op(OP_ADD,   8'd0,   8'd0);
		issue_op(OP_ADD,   8'd255, 8'd0);
		issue_op(OP_ADD,   8'd0,   8'd0);	// duplicate add
		issue_op(OP_ADD,   8'd170, 8'd0);
		issue_op(OP_TEST,  8'd255, 8'd0);
		issue_op(OP_TEST,  8'd1,   8'd0);
		issue_op(OP_READ,  8'd0,   8'd0);
		issue_op(OP_READ,  8'd0,   8'd2);	// last valid slot
		issue_op(OP_READ,  8'd0,   8'd3);	// position == count
		issue_op(OP_READ,  8'd0,   8'd255);
		issue_op(OP_ERASE, 8'd0,   8'd0);	// 170 moves into slot 0
		issue_op(OP_READ,  8'd0,   8'd0);
		issue_op(OP_ERASE, 8'd0,   8'd0);	// already gone
		issue_op(OP_POP,   8'd0,   8'd0);
		issue_op(OP_SPARE_LO, 8'd0, 8'd0);
		issue_op(OP_SPARE_HI, 8'd255, 8'd255);
		issue_op(OP_CLEAR, 8'd0,   8'd0);
		issue_op(OP_TEST,  8'd170, 8'd0);	// member bit gone after clear
		issue_op(OP_POP,   8'd0,   8'd0);
		issue_op(OP_ADD,   8'd85,  8'd0);	// slot 0 rewritten after clear
		issue_op(OP_READ,  8'd0,   8'd0);

		// random traffic, phase by phase: no idling, normal, heavy stall, normal
		for (int phase = 0; phase < 4; phase++) begin
			traffic = (phase == 0) ? TRAFFIC_QUIET
				: (phase == 2) ? TRAFFIC_HEAVY : TRAFFIC_NORMAL;
			for (int i = 0; i < 25; i++)
				issue_random_op();
		end

		// fill the whole universe in shuffled order: count reaches 256
		traffic = TRAFFIC_NORMAL;
		issue_op(OP_CLEAR, 8'd0, 8'd0);
		for (int i = 0; i < UNIVERSE; i++)
			fill_order[i] = ValW'(i);
		for (int i = UNIVERSE - 1; i > 0; i--) begin
			pick = $urandom_range(0, i);
			swap = fill_order[i];
			fill_order[i] = fill_order[pick];
			fill_order[pick] = swap;
		end
		for (int i = 0; i < UNIVERSE; i++)
			issue_op(OP_ADD, fill_order[i], ValW'($urandom_range(0, 255)));
		issue_op(OP_READ,  8'd0, 8'd255);	// top slot of a full set
		issue_op(OP_ADD,   fill_order[17], 8'd0);	// add to full set
		issue_op(OP_TEST,  fill_order[200], 8'd0);
		issue_op(OP_ERASE, fill_order[3], 8'd0);
		issue_op(OP_POP,   8'd0, 8'd0);
		issue_op(OP_READ,  8'd0, 8'd254);	// now past the end
		for (int i = 0; i < 20; i++)
			issue_random_op();
		issue_op(OP_CLEAR, 8'd0, 8'd0);
		issue_op(OP_READ,  8'd0, 8'd0);

		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);

		if (failures == 0)
			$display("tb_sparse_integer_set_core: PASS");
		else
			$display("tb_sparse_integer_set_core: FAIL");
		$finish;
	end

endmodule

`default_nettype wire
